// ===== rtl/core/mcfb_pkg.sv =====
// shared types, field widths and scaling constants of the motor command frame builder
package mcfb_pkg;

  // stream widths (payload padded to whole bytes)
  localparam int S_TDATA_W = 88;
  localparam int S_ITEM_W  = 81;
  localparam int M_TDATA_W = 80;

  localparam int IDENT_W   = 11;
  localparam int PAYLOAD_W = 64;

  // configuration port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic REG_MOTOR_ID  = 1'b0;
  localparam logic REG_STOP_MODE = 1'b1;
  localparam logic [IDENT_W-1:0] MOTOR_ID_RST = 11'd1;

  typedef enum logic [1:0] {
    MODE_RESET = 2'd0,
    MODE_MOTOR = 2'd1,
    MODE_ZERO  = 2'd2,
    MODE_HOLD  = 2'd3   // keep the stored mode
  } mode_e;

  typedef enum logic {
    KIND_MODE = 1'b0,
    KIND_CTRL = 1'b1
  } kind_e;

  localparam logic [7:0] CODE_MOTOR = 8'hFC;
  localparam logic [7:0] CODE_RESET = 8'hFD;
  localparam logic [7:0] CODE_ZERO  = 8'hFE;
  localparam logic [55:0] MODE_FILL = {56{1'b1}};

  // five set values, last field in the low bits as on the stream
  typedef struct packed {
    logic signed [13:0] torque;
    logic signed [15:0] damping;
    logic signed [17:0] stiffness;
    logic signed [14:0] velocity;
    logic signed [15:0] position;
  } setval_t;

  typedef struct packed {
    setval_t     vals;
    logic [1:0]  req_mode;
  } in_item_t;

  // saturation limits
  localparam logic signed [15:0] POS_LIM = 16'sd24448;
  localparam logic signed [14:0] VEL_LIM = 15'sd11520;
  localparam logic signed [17:0] KP_LIM  = 18'sd128000;
  localparam logic signed [15:0] KD_LIM  = 16'sd20480;
  localparam logic signed [13:0] TRQ_LIM = 14'sd4608;

  // offset spans of the saturated values
  localparam longint unsigned POS_SPAN = 48896;
  localparam longint unsigned VEL_SPAN = 23040;
  localparam longint unsigned KP_SPAN  = 128000;
  localparam longint unsigned KD_SPAN  = 20480;
  localparam longint unsigned TRQ_SPAN = 9216;
  localparam longint unsigned FULL16   = 65535;
  localparam longint unsigned FULL12   = 4095;

  // reciprocal shifts: 2**k above span*span keeps the rounded-up reciprocal exact
  localparam int POS_K = 32;
  localparam int VEL_K = 30;
  localparam int KP_K  = 34;
  localparam int KD_K  = 29;
  localparam int TRQ_K = 27;

  localparam longint unsigned POS_MUL_L =
    ((64'd1 << POS_K) * FULL16 + POS_SPAN - 1) / POS_SPAN;
  localparam longint unsigned VEL_MUL_L =
    ((64'd1 << VEL_K) * FULL12 + VEL_SPAN - 1) / VEL_SPAN;
  localparam longint unsigned KP_MUL_L =
    ((64'd1 << KP_K) * FULL12 + KP_SPAN - 1) / KP_SPAN;
  localparam longint unsigned KD_MUL_L =
    ((64'd1 << KD_K) * FULL12 + KD_SPAN - 1) / KD_SPAN;
  localparam longint unsigned TRQ_MUL_L =
    ((64'd1 << TRQ_K) * FULL12 + TRQ_SPAN - 1) / TRQ_SPAN;

  localparam logic [32:0] POS_MUL = POS_MUL_L[32:0];
  localparam logic [27:0] VEL_MUL = VEL_MUL_L[27:0];
  localparam logic [29:0] KP_MUL  = KP_MUL_L[29:0];
  localparam logic [26:0] KD_MUL  = KD_MUL_L[26:0];
  localparam logic [25:0] TRQ_MUL = TRQ_MUL_L[25:0];

  function automatic logic [7:0] mode_code(input mode_e m);
    logic [7:0] c;
    case (m)
      MODE_MOTOR: c = CODE_MOTOR;
      MODE_ZERO:  c = CODE_ZERO;
      default:    c = CODE_RESET;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/core/mcfb_ctrl_pack.sv =====
// saturation, scaling and packing of the five set values into a control payload
module mcfb_ctrl_pack (
  input  mcfb_pkg::setval_t                  vals_i,
  input  logic                               stop_i,
  output logic [mcfb_pkg::PAYLOAD_W-1:0]     payload_o
);
  import mcfb_pkg::*;

  logic signed [15:0] pos;
  logic signed [14:0] vel;
  logic signed [17:0] kp;
  logic signed [15:0] kd;
  logic signed [13:0] trq;

  logic signed [16:0] pos_sum;
  logic signed [15:0] vel_sum;
  logic signed [14:0] trq_sum;

  logic [15:0] pos_off;
  logic [14:0] vel_off;
  logic [16:0] kp_off;
  logic [14:0] kd_off;
  logic [13:0] trq_off;

  logic [48:0] pos_prod;
  logic [42:0] vel_prod;
  logic [46:0] kp_prod;
  logic [41:0] kd_prod;
  logic [39:0] trq_prod;

  always_comb begin
    if (stop_i) begin
      pos = '0;
      vel = '0;
      kp  = '0;
      kd  = '0;
      trq = '0;
    end else begin
      pos = vals_i.position;
      vel = vals_i.velocity;
      kp  = vals_i.stiffness;
      kd  = vals_i.damping;
      trq = vals_i.torque;
    end

    pos_sum = {pos[15], pos} + {POS_LIM[15], POS_LIM};
    vel_sum = {vel[14], vel} + {VEL_LIM[14], VEL_LIM};
    trq_sum = {trq[13], trq} + {TRQ_LIM[13], TRQ_LIM};

    // symmetric ranges become offsets from the lower limit
    if (pos < -POS_LIM)      pos_off = '0;
    else if (pos > POS_LIM)  pos_off = 16'(POS_SPAN);
    else                     pos_off = pos_sum[15:0];

    if (vel < -VEL_LIM)      vel_off = '0;
    else if (vel > VEL_LIM)  vel_off = 15'(VEL_SPAN);
    else                     vel_off = vel_sum[14:0];

    if (kp < 18'sd0)         kp_off = '0;
    else if (kp > KP_LIM)    kp_off = 17'(KP_SPAN);
    else                     kp_off = kp[16:0];

    if (kd < 16'sd0)         kd_off = '0;
    else if (kd > KD_LIM)    kd_off = 15'(KD_SPAN);
    else                     kd_off = kd[14:0];

    if (trq < -TRQ_LIM)      trq_off = '0;
    else if (trq > TRQ_LIM)  trq_off = 14'(TRQ_SPAN);
    else                     trq_off = trq_sum[13:0];
  end

  // division by the span as a multiply by its rounded-up reciprocal
  assign pos_prod = 49'(pos_off) * 49'(POS_MUL);
  assign vel_prod = 43'(vel_off) * 43'(VEL_MUL);
  assign kp_prod  = 47'(kp_off)  * 47'(KP_MUL);
  assign kd_prod  = 42'(kd_off)  * 42'(KD_MUL);
  assign trq_prod = 40'(trq_off) * 40'(TRQ_MUL);

  assign payload_o = {pos_prod[POS_K +: 16],
                      vel_prod[VEL_K +: 12],
                      kp_prod[KP_K +: 12],
                      kd_prod[KD_K +: 12],
                      trq_prod[TRQ_K +: 12]};

endmodule

// ===== rtl/core/motor_command_frame_builder.sv =====
// top level: input stage, mode tracking, frame result register and register port
// Each tick taken on the slave stream gives at most one frame on the master stream,
// passing the input register and then the result register. A tick whose
// requested mode differs from the stored one gives a mode frame and updates the stored
// mode; otherwise, in motor mode, it gives a control frame; in other cases it gives no
// frame. One tick is accepted every cycle: an input register and a result register
// hold one tick each, so the slave side stalls only when both are full and the master
// side is not ready. motor_id and stop_mode are to be written while no tick is in
// flight; they act on every frame built after the write.
module motor_command_frame_builder (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // slave stream
  input  logic                             s_tvalid_i,
  output logic                             s_tready_o,
  // requested_mode, position_cmd, velocity_cmd, stiffness_cmd, damping_cmd, torque_cmd
  input  logic [mcfb_pkg::S_TDATA_W-1:0]   s_tdata_i,
  // master stream
  output logic                             m_tvalid_o,
  input  logic                             m_tready_i,
  // frame_ident, frame_payload
  output logic [mcfb_pkg::M_TDATA_W-1:0]   m_tdata_o,
  // frame_kind
  output logic                             m_tuser_o,
  // register port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [mcfb_pkg::APB_AW-1:0]      paddr,
  input  logic [mcfb_pkg::APB_DW-1:0]      pwdata,
  output logic [mcfb_pkg::APB_DW-1:0]      prdata,
  output logic                             pready
);
  import mcfb_pkg::*;

  logic                 cfg_we;
  logic [IDENT_W-1:0]   motor_id_q;
  logic                 stop_mode_q;

  logic                 in_valid_q;
  in_item_t             in_item_q;

  mode_e                cur_mode_q;
  mode_e                req_mode;
  mode_e                eff_mode;
  logic                 advance;
  logic                 emit;
  kind_e                kind;
  logic [PAYLOAD_W-1:0] ctrl_payload;
  logic [PAYLOAD_W-1:0] frame_payload;

  logic                 out_valid_q;
  kind_e                out_kind_q;
  logic [IDENT_W-1:0]   out_ident_q;
  logic [PAYLOAD_W-1:0] out_payload_q;

  // register port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      motor_id_q  <= MOTOR_ID_RST;
      stop_mode_q <= 1'b0;
    end else if (cfg_we) begin
      case (paddr[2])
        REG_MOTOR_ID:  motor_id_q  <= pwdata[IDENT_W-1:0];
        REG_STOP_MODE: stop_mode_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_MOTOR_ID:  prdata = {{(APB_DW-IDENT_W){1'b0}}, motor_id_q};
      REG_STOP_MODE: prdata = {{(APB_DW-1){1'b0}}, stop_mode_q};
      default:       prdata = '0;
    endcase
  end

  // input stage
  assign advance    = !out_valid_q || m_tready_i;
  assign s_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_tready_o) begin
      in_valid_q <= s_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_tvalid_i && s_tready_o) begin
      in_item_q <= in_item_t'(s_tdata_i[S_ITEM_W-1:0]);
    end
  end

  // frame decision
  mcfb_ctrl_pack u_ctrl_pack (
    .vals_i    (in_item_q.vals),
    .stop_i    (stop_mode_q),
    .payload_o (ctrl_payload)
  );

  always_comb begin
    req_mode = mode_e'(in_item_q.req_mode);
    eff_mode = (req_mode == MODE_HOLD) ? cur_mode_q : req_mode;
    if (eff_mode != cur_mode_q) begin
      emit          = 1'b1;
      kind          = KIND_MODE;
      frame_payload = {MODE_FILL, mode_code(eff_mode)};
    end else begin
      emit          = (cur_mode_q == MODE_MOTOR);
      kind          = KIND_CTRL;
      frame_payload = ctrl_payload;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_mode_q  <= MODE_RESET;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q && emit;
      if (in_valid_q) begin
        cur_mode_q <= eff_mode;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q && emit) begin
      out_kind_q    <= kind;
      out_ident_q   <= motor_id_q;
      out_payload_q <= frame_payload;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tuser_o  = out_kind_q;
  assign m_tdata_o  = {{(M_TDATA_W-PAYLOAD_W-IDENT_W){1'b0}}, out_payload_q, out_ident_q};

  // a held control frame means the last tick left the block in motor mode
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_kind_q == KIND_CTRL) |-> cur_mode_q == MODE_MOTOR)
    else $error("control frame held while stored mode is not motor");

  // a held mode frame carries the code of the mode it switched to
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_kind_q == KIND_MODE) |->
      (out_payload_q == {MODE_FILL, mode_code(cur_mode_q)}))
    else $error("mode frame does not match stored mode");

  // the slave side stalls only with both stages full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_tready_o |-> (in_valid_q && out_valid_q && !m_tready_i))
    else $error("slave stream stalled with room in the pipeline");

endmodule

// ===== verif/tb.sv =====
// self-checking testbench for the motor command frame builder: stream ticks in, CAN frames out
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mcfb_pkg::*;

  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 120;
  localparam logic [APB_AW-1:0] ADDR_MOTOR_ID  = {REG_MOTOR_ID, 2'b00};
  localparam logic [APB_AW-1:0] ADDR_STOP_MODE = {REG_STOP_MODE, 2'b00};

  typedef struct {
    logic [IDENT_W-1:0]   ident;
    kind_e                kind;
    logic [PAYLOAD_W-1:0] payload;
  } frame_t;

  class frame_checker;
    logic [IDENT_W-1:0] motor_id;
    bit                 stop_mode;
    mode_e              cur_mode;
    frame_t             pending_frames[$];
    int                 errors;
    int                 issued;

    function new();
      motor_id  = MOTOR_ID_RST;
      stop_mode = 1'b0;
      cur_mode  = MODE_RESET;
      errors    = 0;
      issued    = 0;
    endfunction

    static function int sat(int x, int lo, int hi);
      if (x < lo) return lo;
      if (x > hi) return hi;
      return x;
    endfunction

    // offset from the low limit, scaled and truncated
    static function longint unsigned to_code(int x, int lo, longint unsigned full,
                                             longint unsigned span);
      longint unsigned off;
      off = longint'(longint'(x) - longint'(lo));
      return (off * full) / span;
    endfunction

    function void note_tick(in_item_t it);
      mode_e             req;
      frame_t            f;
      int                p, v, kp, kd, t;
      logic [15:0]       cp;
      logic [11:0]       cv, ckp, ckd, ct;
      issued++;
      req = mode_e'(it.req_mode);
      if (req == MODE_HOLD) req = cur_mode;
      f.ident = motor_id;
      if (req != cur_mode) begin
        cur_mode = req;
        f.kind   = KIND_MODE;
        case (req)
          MODE_MOTOR: f.payload = {MODE_FILL, CODE_MOTOR};
          MODE_ZERO:  f.payload = {MODE_FILL, CODE_ZERO};
          default:    f.payload = {MODE_FILL, CODE_RESET};
        endcase
      end else if (cur_mode == MODE_MOTOR) begin
        p  = $signed(it.vals.position);
        v  = $signed(it.vals.velocity);
        kp = $signed(it.vals.stiffness);
        kd = $signed(it.vals.damping);
        t  = $signed(it.vals.torque);
        if (stop_mode) begin
          p = 0; v = 0; kp = 0; kd = 0; t = 0;
        end
        p  = sat(p, -int'(POS_LIM), int'(POS_LIM));
        v  = sat(v, -int'(VEL_LIM), int'(VEL_LIM));
        kp = sat(kp, 0, int'(KP_LIM));
        kd = sat(kd, 0, int'(KD_LIM));
        t  = sat(t, -int'(TRQ_LIM), int'(TRQ_LIM));
        cp  = 16'(to_code(p, -int'(POS_LIM), FULL16, POS_SPAN));
        cv  = 12'(to_code(v, -int'(VEL_LIM), FULL12, VEL_SPAN));
        ckp = 12'(to_code(kp, 0, FULL12, KP_SPAN));
        ckd = 12'(to_code(kd, 0, FULL12, KD_SPAN));
        ct  = 12'(to_code(t, -int'(TRQ_LIM), FULL12, TRQ_SPAN));
        f.kind    = KIND_CTRL;
        f.payload = {cp, cv, ckp, ckd, ct};
      end else begin
        return;
      end
      pending_frames.push_back(f);
    endfunction

    function void check_frame(logic [IDENT_W-1:0] ident, logic kind,
                              logic [PAYLOAD_W-1:0] payload);
      frame_t f;
      if (pending_frames.size() == 0) begin
        $display("%0t: frame with none pending: ident %h kind %0d payload %h",
                 $time, ident, kind, payload);
        errors++;
        return;
      end
      f = pending_frames.pop_front();
      if (ident !== f.ident) begin
        $display("%0t: ident expected %h actual %h", $time, f.ident, ident);
        errors++;
      end
      if (kind !== f.kind) begin
        $display("%0t: kind expected %0d actual %0d", $time, f.kind, kind);
        errors++;
      end
      if (payload !== f.payload) begin
        $display("%0t: payload expected %h actual %h", $time, f.payload, payload);
        errors++;
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 s_tvalid_i;
  logic                 s_tready_o;
  logic [S_TDATA_W-1:0] s_tdata_i;
  logic                 m_tvalid_o;
  logic                 m_tready_i;
  logic [M_TDATA_W-1:0] m_tdata_o;
  logic                 m_tuser_o;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [APB_AW-1:0]    paddr;
  logic [APB_DW-1:0]    pwdata;
  logic [APB_DW-1:0]    prdata;
  logic                 pready;

  frame_checker sb;
  int src_idle;
  int sink_idle;
  bit hold_req;
  int hold_left;
  int quiet;

  motor_command_frame_builder i_dut (.*);

  always #1 clk_i = ~clk_i;

  // register write followed by a readback
  task automatic write_reg(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data,
                           input logic [APB_DW-1:0] readback);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== readback) begin
      $display("%0t: readback at %0d expected %h actual %h", $time, addr, readback, prdata);
      sb.errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_config(input logic [APB_DW-1:0] id_raw, input logic [APB_DW-1:0] stop_raw);
    write_reg(ADDR_MOTOR_ID, id_raw, APB_DW'(id_raw[IDENT_W-1:0]));
    sb.motor_id = id_raw[IDENT_W-1:0];
    write_reg(ADDR_STOP_MODE, stop_raw, APB_DW'(stop_raw[0]));
    sb.stop_mode = stop_raw[0];
  endtask

  task automatic send_tick(input in_item_t it);
    while ($urandom_range(99) < src_idle) begin
      s_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= S_TDATA_W'(it);
    do @(posedge clk_i); while (!s_tready_o);
    sb.note_tick(it);
  endtask

  task automatic drain();
    s_tvalid_i <= 1'b0;
    while (sb.pending_frames.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic in_item_t tick(mode_e m, int p, int v, int kp, int kd, int t);
    in_item_t it;
    it.req_mode       = m;
    it.vals.position  = 16'(p);
    it.vals.velocity  = 15'(v);
    it.vals.stiffness = 18'(kp);
    it.vals.damping   = 16'(kd);
    it.vals.torque    = 14'(t);
    return it;
  endfunction

  // mix of raw bits, in-range values, values around the limits and around zero, and field extremes
  function automatic int rand_val(int lo, int hi, int w);
    case ($urandom_range(9))
      0, 1, 2, 3: return int'($urandom);
      4, 5:       return lo + int'($urandom_range(hi - lo));
      6:          return lo + int'($urandom_range(6)) - 3;
      7:          return hi + int'($urandom_range(6)) - 3;
      8:          return $urandom_range(1) ? (1 << (w - 1)) - 1 : -(1 << (w - 1));
      default:    return int'($urandom_range(6)) - 3;
    endcase
  endfunction

  function automatic in_item_t rand_tick();
    int    r;
    mode_e m;
    r = $urandom_range(99);
    if (r < 45)      m = MODE_MOTOR;
    else if (r < 85) m = MODE_HOLD;
    else if (r < 92) m = MODE_RESET;
    else             m = MODE_ZERO;
    return tick(m, rand_val(-int'(POS_LIM), int'(POS_LIM), 16),
                rand_val(-int'(VEL_LIM), int'(VEL_LIM), 15),
                rand_val(0, int'(KP_LIM), 18),
                rand_val(0, int'(KD_LIM), 16),
                rand_val(-int'(TRQ_LIM), int'(TRQ_LIM), 14));
  endfunction

  task automatic random_run(input int n);
    int target;
    target = sb.issued + n;
    while (sb.issued < target) send_tick(rand_tick());
  endtask

  // frame sink with random stalls and an occasional long hold-off
  initial begin
    forever begin
      @(posedge clk_i);
      if (m_tvalid_o && m_tready_i)
        sb.check_frame(m_tdata_o[IDENT_W-1:0], m_tuser_o, m_tdata_o[IDENT_W +: PAYLOAD_W]);
      if (hold_left > 0) begin
        hold_left--;
        m_tready_i <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
        m_tready_i <= 1'b0;
      end else begin
        m_tready_i <= ($urandom_range(99) >= sink_idle);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_tvalid_i && s_tready_o) || (m_tvalid_o && m_tready_i)) quiet = 0;
    else quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  initial begin
    sb        = new();
    src_idle  = 0;
    sink_idle = 0;
    hold_req  = 1'b0;
    hold_left = 0;
    quiet     = 0;
    rst_ni     <= 1'b0;
    s_tvalid_i <= 1'b0;
    s_tdata_i  <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed ticks under reset configuration
    sink_idle = 40;
    send_tick(tick(MODE_RESET, 0, 0, 0, 0, 0));
    send_tick(tick(MODE_HOLD, 100, 100, 100, 100, 100));
    send_tick(tick(MODE_ZERO, 0, 0, 0, 0, 0));
    send_tick(tick(MODE_HOLD, 0, 0, 0, 0, 0));
    send_tick(tick(MODE_ZERO, 5, 5, 5, 5, 5));
    send_tick(tick(MODE_MOTOR, 0, 0, 0, 0, 0));
    send_tick(tick(MODE_MOTOR, 32767, 16383, 131071, 32767, 8191));
    send_tick(tick(MODE_MOTOR, -32768, -16384, -131072, -32768, -8192));
    send_tick(tick(MODE_MOTOR, 0, 0, 0, 0, 0));
    send_tick(tick(MODE_MOTOR, 24448, 11520, 128000, 20480, 4608));
    send_tick(tick(MODE_MOTOR, -24448, -11520, 0, 0, -4608));
    send_tick(tick(MODE_MOTOR, 24449, 11521, 128001, 20481, 4609));
    send_tick(tick(MODE_MOTOR, -24449, -11521, -1, -1, -4609));
    send_tick(tick(MODE_MOTOR, 24447, 11519, 127999, 20479, 4607));
    send_tick(tick(MODE_HOLD, 1234, -567, 64000, 10240, -999));
    send_tick(tick(MODE_RESET, 1, 1, 1, 1, 1));
    send_tick(tick(MODE_MOTOR, 0, 0, 0, 0, 0));
    send_tick(tick(MODE_ZERO, 0, 0, 0, 0, 0));
    send_tick(tick(MODE_MOTOR, 0, 0, 0, 0, 0));
    send_tick(tick(MODE_HOLD, -1, -1, 1, 1, -1));
    drain();

    // upper bits of the write data are dropped
    set_config(32'hFFFF_FFFF, 32'h0000_0000);
    src_idle  = 15;
    sink_idle = 86;
    hold_req  = 1'b1;
    random_run(220);
    drain();

    // stop mode: every control frame carries the codes of zero
    set_config(32'h0000_0000, 32'h8000_0001);
    src_idle  = 86;
    sink_idle = 15;
    random_run(40);
    drain();

    set_config(32'($urandom_range(2047)), 32'h0000_0000);
    random_run(180);
    drain();

    set_config($urandom, 32'hFFFF_FFFE);
    src_idle  = 0;
    sink_idle = 0;
    hold_req  = 1'b1;
    random_run(220);
    drain();

    if (sb.errors == 0 && sb.pending_frames.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/mcfb_pkg.sv
rtl/core/mcfb_ctrl_pack.sv
rtl/core/motor_command_frame_builder.sv
verif/tb.sv
